/* design/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and color helpers for the BC1/BC2 block decoder.
// ----------------------------------------------------------------------------
package bbd_pkg;

    // Block geometry
    localparam int unsigned NUM_PIX = 16;
    localparam int unsigned PIX_W   = $clog2(NUM_PIX);

    // Front-to-back queue
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Divide by three: x/3 == (x*683) >> 11 for all x below 1536
    localparam logic [9:0]  DIV3_MUL   = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_ZERO    = 8'h00;

    // Palette codes
    typedef enum logic [1:0] {
        CODE_C0    = 2'd0,
        CODE_C1    = 2'd1,
        CODE_MIX_A = 2'd2,
        CODE_MIX_B = 2'd3
    } t_code;

    typedef logic [7:0] t_chan;

    typedef struct packed {
        t_chan r;
        t_chan g;
        t_chan b;
    } t_rgb;

    // One classified block as it travels from front to back
    typedef struct packed {
        t_rgb [3:0]  pal;     // four palette entries, indexed by code
        logic        dxt3;    // explicit alpha from nibbles
        logic        punch;   // three-color block, code 3 is transparent
        logic [31:0] codes;
        logic [63:0] alphas;
    } t_blk;

    // One decoded pixel
    typedef struct packed {
        t_chan            r;
        t_chan            g;
        t_chan            b;
        t_chan            a;
        logic [PIX_W-1:0] idx;
        logic             last;
    } t_pix;

    // 5-bit to 8-bit by bit replication
    function automatic t_chan widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // 6-bit to 8-bit by bit replication
    function automatic t_chan widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic t_rgb expand565(input logic [15:0] c);
        t_rgb res;
        res.r = widen5(c[15:11]);
        res.g = widen6(c[10:5]);
        res.b = widen5(c[4:0]);
        return res;
    endfunction

    // floor(x/3) by reciprocal multiply, x up to 765
    function automatic t_chan div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(DIV3_MUL);
        return prod[DIV3_SHIFT +: 8];
    endfunction

    // Two interpolated entries for one channel: {code 2, code 3}
    function automatic logic [15:0] mix_chan(input t_chan a, input t_chan b,
                                             input logic four);
        logic [9:0] s_a;
        logic [9:0] s_b;
        logic [8:0] s_ab;
        s_a  = {1'b0, a, 1'b0} + {2'b00, b};
        s_b  = {2'b00, a} + {1'b0, b, 1'b0};
        s_ab = {1'b0, a} + {1'b0, b};
        if (four) begin
            return {div3(s_a), div3(s_b)};
        end else begin
            return {s_ab[8:1], CHAN_ZERO};
        end
    endfunction

endpackage

/* design/bbd_front.sv */
// ----------------------------------------------------------------------------
// bbd_front
// Accepts compressed blocks, holds the format register and builds the
// four-entry palette; hands classified blocks to the queue.
// ----------------------------------------------------------------------------
module bbd_front import bbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_endpoint_zero,
    input  logic [15:0] i_endpoint_one,
    input  logic [31:0] i_index_bits,
    input  logic [63:0] i_explicit_alpha,
    output logic        o_q_wr,
    output t_blk        o_q_din,
    input  logic        i_q_full
);

    logic        r_fmt;
    logic        r_vld;
    logic [15:0] r_e0;
    logic [15:0] r_e1;
    logic [31:0] r_codes;
    logic [63:0] r_alphas;
    logic        r_dxt3;

    logic        acc;
    logic        four;
    t_rgb        c0;
    t_rgb        c1;
    logic [15:0] mix_r;
    logic [15:0] mix_g;
    logic [15:0] mix_b;

    // Stage moves on when the queue has room
    assign o_q_wr = r_vld && !i_q_full;
    assign full   = r_vld && i_q_full;
    assign acc    = push && !full;

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_fmt <= i_cfg_wr_data;
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (o_q_wr) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_e0     <= i_endpoint_zero;
            r_e1     <= i_endpoint_one;
            r_codes  <= i_index_bits;
            r_alphas <= i_explicit_alpha;
            r_dxt3   <= r_fmt;
        end
    end

    // Classify and build the palette
    always_comb begin
        four  = r_dxt3 || (r_e0 > r_e1);
        c0    = expand565(r_e0);
        c1    = expand565(r_e1);
        mix_r = mix_chan(c0.r, c1.r, four);
        mix_g = mix_chan(c0.g, c1.g, four);
        mix_b = mix_chan(c0.b, c1.b, four);

        o_q_din.pal[CODE_C0]    = c0;
        o_q_din.pal[CODE_C1]    = c1;
        o_q_din.pal[CODE_MIX_A] = '{r: mix_r[15:8], g: mix_g[15:8], b: mix_b[15:8]};
        o_q_din.pal[CODE_MIX_B] = '{r: mix_r[7:0], g: mix_g[7:0], b: mix_b[7:0]};
        o_q_din.dxt3            = r_dxt3;
        o_q_din.punch           = !four;
        o_q_din.codes           = r_codes;
        o_q_din.alphas          = r_alphas;
    end

endmodule

/* design/bbd_queue.sv */
// ----------------------------------------------------------------------------
// bbd_queue
// Short first-in first-out queue of classified blocks between front and back.
// ----------------------------------------------------------------------------
module bbd_queue import bbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_blk i_din,
    output logic o_full,
    input  logic i_rd,
    output logic o_vld,
    output t_blk o_dout
);

    t_blk              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign do_wr  = i_wr && !o_full;
    assign do_rd  = i_rd && o_vld;
    assign o_dout = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

endmodule

/* design/bbd_back.sv */
// ----------------------------------------------------------------------------
// bbd_back
// Walks the sixteen pixels of the current block, one per cycle while the
// result register is free or popped, into a registered result stage.
// ----------------------------------------------------------------------------
module bbd_back import bbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_vld,
    input  t_blk i_q_dout,
    output logic o_q_rd,
    output logic o_out_vld,
    output t_pix o_pix,
    input  logic pop
);

    t_blk             r_ent;
    logic             r_act;
    logic [PIX_W-1:0] r_cnt;
    logic             r_out_vld;
    t_pix             r_out;

    logic             adv;
    logic             at_last;
    t_code            code;
    logic [3:0]       nib;
    t_rgb             col;
    t_pix             n_out;

    assign at_last   = (r_cnt == PIX_W'(NUM_PIX - 1));
    assign adv       = r_act && (!r_out_vld || pop);
    assign o_q_rd    = i_q_vld && (!r_act || (adv && at_last));
    assign o_out_vld = r_out_vld;
    assign o_pix     = r_out;

    // Decode the current pixel
    always_comb begin
        code = t_code'(r_ent.codes[{r_cnt, 1'b0} +: 2]);
        nib  = r_ent.alphas[{r_cnt, 2'b00} +: 4];
        col  = r_ent.pal[code];

        n_out.r    = col.r;
        n_out.g    = col.g;
        n_out.b    = col.b;
        n_out.idx  = r_cnt;
        n_out.last = at_last;
        if (r_ent.dxt3) begin
            n_out.a = {nib, nib};
        end else if (r_ent.punch && (code == CODE_MIX_B)) begin
            n_out.a = CHAN_ZERO;
        end else begin
            n_out.a = ALPHA_OPAQUE;
        end
    end

    // Block sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (adv) begin
                r_cnt <= at_last ? '0 : r_cnt + 1'b1;
            end
            if (!r_act || (adv && at_last)) begin
                r_act <= i_q_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_ent <= i_q_dout;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // A new block is taken only when none is in progress or the last pixel leaves
    a_load_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_rd |-> (!r_act || (adv && at_last)))
        else $error("block loaded in the middle of another block");

    // Pixel counter holds while the sequencer is stalled
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !adv) |=> $stable(r_cnt))
        else $error("pixel counter moved while stalled");

    // Last flag marks pixel fifteen only
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.last == (r_out.idx == PIX_W'(NUM_PIX - 1))))
        else $error("last flag does not match pixel index");

    // Counter rests at zero when no block is active
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_act |-> (r_cnt == '0))
        else $error("pixel counter not at zero while idle");
`endif

endmodule

/* design/bc1_bc2_block_decoder_top.sv */
// Pipeline: a block passes the input stage, the queue and the back end's block
// register before its first pixel is registered for the result ports; the other 15
// follow. Throughput: one pixel per cycle while pop keeps up, set by the
// single-pixel result register; a two-deep queue lets input run ahead.
// Reset: synchronous, active low; clears the format register to DXT1 and
// empties the input stage, the queue and the result register.
// ----------------------------------------------------------------------------
// bc1_bc2_block_decoder_top
// BC1/BC2 (DXT1/DXT3) 4x4 block decoder: compressed block in, sixteen
// RGBA8888 pixels out in raster order.
// ----------------------------------------------------------------------------
module bc1_bc2_block_decoder_top import bbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_endpoint_zero,
    input  logic [15:0] i_endpoint_one,
    input  logic [31:0] i_index_bits,
    input  logic [63:0] i_explicit_alpha,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_pixel_red,
    output logic [7:0]  o_pixel_green,
    output logic [7:0]  o_pixel_blue,
    output logic [7:0]  o_pixel_alpha,
    output logic [3:0]  o_pixel_index,
    output logic        o_last_pixel
);

    logic q_wr;
    t_blk q_din;
    logic q_full;
    logic q_rd;
    logic q_vld;
    t_blk q_dout;
    logic out_vld;
    t_pix pix;

    // Front: accept and classify
    bbd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_endpoint_zero  (i_endpoint_zero),
        .i_endpoint_one   (i_endpoint_one),
        .i_index_bits     (i_index_bits),
        .i_explicit_alpha (i_explicit_alpha),
        .o_q_wr           (q_wr),
        .o_q_din          (q_din),
        .i_q_full         (q_full)
    );

    // Decoupling queue
    bbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_din   (q_din),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_vld   (q_vld),
        .o_dout  (q_dout)
    );

    // Back: pixel sequencer
    bbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_dout  (q_dout),
        .o_q_rd    (q_rd),
        .o_out_vld (out_vld),
        .o_pix     (pix),
        .pop       (pop)
    );

    assign empty         = !out_vld;
    assign o_pixel_red   = pix.r;
    assign o_pixel_green = pix.g;
    assign o_pixel_blue  = pix.b;
    assign o_pixel_alpha = pix.a;
    assign o_pixel_index = pix.idx;
    assign o_last_pixel  = pix.last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the BC1/BC2 block decoder: compressed 4x4 blocks go in through the
// push/full side, and every decoded pixel that leaves through empty/pop is
// compared with a per-block pixel model kept here. Directed blocks come first,
// then random blocks in phases with different block formats. Both sides idle.
// ----------------------------------------------------------------------------
module testbench;
    import bbd_pkg::*;

    localparam int unsigned PIX_PER_BLOCK = 16;
    localparam int unsigned RAND_PHASES   = 5;
    localparam int unsigned PHASE_BLOCKS  = 61;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 20;

    // Block format register values
    localparam bit FMT_DXT1 = 1'b0;
    localparam bit FMT_DXT3 = 1'b1;

    // One decoded pixel as the result ports show it
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] index;
        logic       last;
    } pixel_t;

    // One directed block; uniform rows carry their expected RGBA directly
    typedef struct {
        bit          fmt;
        logic [15:0] e0;
        logic [15:0] e1;
        logic [31:0] codes;
        logic [63:0] alphas;
        bit          uniform;
        logic [31:0] rgba;
    } directed_block_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_endpoint_zero = '0;
    logic [15:0] i_endpoint_one = '0;
    logic [31:0] i_index_bits = '0;
    logic [63:0] i_explicit_alpha = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_pixel_red;
    logic [7:0]  o_pixel_green;
    logic [7:0]  o_pixel_blue;
    logic [7:0]  o_pixel_alpha;
    logic [3:0]  o_pixel_index;
    logic        o_last_pixel;

    pixel_t          pending_pixels[$];
    directed_block_t directed_blocks [0:15];
    bit              cur_format = FMT_DXT1;
    bit              hold_req = 1'b0;
    bit              send_burst = 1'b0;
    int unsigned     error_count = 0;

    bc1_bc2_block_decoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_endpoint_zero  (i_endpoint_zero),
        .i_endpoint_one   (i_endpoint_one),
        .i_index_bits     (i_index_bits),
        .i_explicit_alpha (i_explicit_alpha),
        .empty            (empty),
        .pop              (pop),
        .o_pixel_red      (o_pixel_red),
        .o_pixel_green    (o_pixel_green),
        .o_pixel_blue     (o_pixel_blue),
        .o_pixel_alpha    (o_pixel_alpha),
        .o_pixel_index    (o_pixel_index),
        .o_last_pixel     (o_last_pixel)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Decode one block into sixteen expected pixels
    function automatic void predict_block_pixels(input bit fmt, input logic [15:0] e0,
                                                 input logic [15:0] e1,
                                                 input logic [31:0] codes,
                                                 input logic [63:0] alphas);
        logic [7:0]  col0 [3];
        logic [7:0]  col1 [3];
        logic [7:0]  pal [4][4];
        bit          four_color;
        logic [1:0]  code;
        logic [3:0]  nib;
        pixel_t      px;
        four_color = (fmt == FMT_DXT3) || (e0 > e1);
        col0[0] = {e0[15:11], e0[15:13]};
        col0[1] = {e0[10:5], e0[10:9]};
        col0[2] = {e0[4:0], e0[4:2]};
        col1[0] = {e1[15:11], e1[15:13]};
        col1[1] = {e1[10:5], e1[10:9]};
        col1[2] = {e1[4:0], e1[4:2]};
        for (int ch = 0; ch < 3; ch++) begin
            pal[0][ch] = col0[ch];
            pal[1][ch] = col1[ch];
            if (four_color) begin
                pal[2][ch] = 8'((2 * int'(col0[ch]) + int'(col1[ch])) / 3);
                pal[3][ch] = 8'((int'(col0[ch]) + 2 * int'(col1[ch])) / 3);
            end else begin
                pal[2][ch] = 8'((int'(col0[ch]) + int'(col1[ch])) / 2);
                pal[3][ch] = 8'h00;
            end
        end
        pal[0][3] = 8'hFF;
        pal[1][3] = 8'hFF;
        pal[2][3] = 8'hFF;
        pal[3][3] = four_color ? 8'hFF : 8'h00;
        for (int i = 0; i < PIX_PER_BLOCK; i++) begin
            code = codes[2*i +: 2];
            nib  = alphas[4*i +: 4];
            px.red   = pal[code][0];
            px.green = pal[code][1];
            px.blue  = pal[code][2];
            px.alpha = (fmt == FMT_DXT3) ? {nib, nib} : pal[code][3];
            px.index = 4'(i);
            px.last  = (i == PIX_PER_BLOCK - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    // Offer one block and return at the edge where it is transferred
    task automatic send_block(input logic [15:0] e0, input logic [15:0] e1,
                              input logic [31:0] codes, input logic [63:0] alphas);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_endpoint_zero  <= e0;
        i_endpoint_one   <= e1;
        i_index_bits     <= codes;
        i_explicit_alpha <= alphas;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected pixel has come out
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Format register write, only with the block idle
    task automatic set_format(input bit fmt);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= fmt;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_format = fmt;
    endtask

    // Random block, biased toward the three-color / four-color boundary
    task automatic send_random_block();
        logic [15:0] e0;
        logic [15:0] e1;
        logic [15:0] tmp;
        logic [31:0] codes;
        logic [63:0] alphas;
        int unsigned kind;
        e0     = 16'($urandom);
        e1     = 16'($urandom);
        codes  = $urandom;
        alphas = {$urandom, $urandom};
        kind   = $urandom_range(0, 9);
        case (kind)
            0: begin
                e1 = e0;
            end
            1: begin
                e0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                e1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            2, 3, 4: begin
                if (e0 > e1) begin
                    tmp = e0;
                    e0  = e1;
                    e1  = tmp;
                end
            end
            default: begin
            end
        endcase
        // Sometimes the whole block uses one code
        if ($urandom_range(0, 7) == 0) begin
            codes = {16{2'($urandom_range(0, 3))}};
        end
        send_block(e0, e1, codes, alphas);
        predict_block_pixels(cur_format, e0, e1, codes, alphas);
    endtask

    // Stimulus
    initial begin
        pixel_t px;
        // fmt, endpoint 0, endpoint 1, codes, alphas, uniform, RGBA
        directed_blocks[0]  = '{FMT_DXT1, 16'hFFFF, 16'h0000, 32'h0000_0000,
                                64'h0, 1'b1, 32'hFFFF_FFFF};
        directed_blocks[1]  = '{FMT_DXT1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                                64'h0, 1'b1, 32'h5555_55FF};
        directed_blocks[2]  = '{FMT_DXT1, 16'hFFFF, 16'h0000, 32'hAAAA_AAAA,
                                64'h0, 1'b1, 32'hAAAA_AAFF};
        directed_blocks[3]  = '{FMT_DXT1, 16'h0000, 16'h0000, 32'hFFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_0000};
        directed_blocks[4]  = '{FMT_DXT1, 16'h0000, 16'hFFFF, 32'hAAAA_AAAA,
                                64'h0, 1'b1, 32'h7F7F_7FFF};
        directed_blocks[5]  = '{FMT_DXT1, 16'h0000, 16'hFFFF, 32'h5555_5555,
                                64'h0, 1'b1, 32'hFFFF_FFFF};
        directed_blocks[6]  = '{FMT_DXT1, 16'h1234, 16'h1234, 32'hE4E4_E4E4,
                                64'h0, 1'b0, 32'h0};
        directed_blocks[7]  = '{FMT_DXT1, 16'hF800, 16'h07E0, 32'h1B1B_1B1B,
                                64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0};
        directed_blocks[8]  = '{FMT_DXT1, 16'h001F, 16'hF800, 32'hE4E4_E4E4,
                                64'h0123_4567_89AB_CDEF, 1'b0, 32'h0};
        directed_blocks[9]  = '{FMT_DXT1, 16'h8000, 16'h7FFF, 32'h3399_CC66,
                                64'h0, 1'b0, 32'h0};
        directed_blocks[10] = '{FMT_DXT1, 16'h7FFF, 16'h8000, 32'h6C6C_9393,
                                64'h0, 1'b0, 32'h0};
        directed_blocks[11] = '{FMT_DXT3, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
                                64'h0, 1'b1, 32'hAAAA_AA00};
        directed_blocks[12] = '{FMT_DXT3, 16'h0000, 16'h0000, 32'hFFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_00FF};
        directed_blocks[13] = '{FMT_DXT3, 16'hFFFF, 16'h0000, 32'h0000_0000,
                                64'h0123_4567_89AB_CDEF, 1'b0, 32'h0};
        directed_blocks[14] = '{FMT_DXT3, 16'h1234, 16'hABCD, 32'hE4E4_E4E4,
                                64'hFEDC_BA98_7654_3210, 1'b0, 32'h0};
        directed_blocks[15] = '{FMT_DXT3, 16'h07E0, 16'h001F, 32'h1B1B_1B1B,
                                64'hAAAA_5555_AAAA_5555, 1'b0, 32'h0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks; uniform ones carry their pixel color directly
        foreach (directed_blocks[n]) begin
            if (directed_blocks[n].fmt != cur_format) begin
                set_format(directed_blocks[n].fmt);
            end
            send_block(directed_blocks[n].e0, directed_blocks[n].e1,
                       directed_blocks[n].codes, directed_blocks[n].alphas);
            if (directed_blocks[n].uniform) begin
                for (int i = 0; i < PIX_PER_BLOCK; i++) begin
                    {px.red, px.green, px.blue, px.alpha} = directed_blocks[n].rgba;
                    px.index = 4'(i);
                    px.last  = (i == PIX_PER_BLOCK - 1);
                    pending_pixels.push_back(px);
                end
            end else begin
                predict_block_pixels(cur_format, directed_blocks[n].e0,
                                     directed_blocks[n].e1, directed_blocks[n].codes,
                                     directed_blocks[n].alphas);
            end
        end

        // Random phases, each opened with a format write
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                set_format(FMT_DXT1);
            end else if (p == 1) begin
                set_format(FMT_DXT3);
            end else begin
                set_format(1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < PHASE_BLOCKS; k++) begin
                // Output side holds off while input keeps coming
                if (p == 0 && k == 20) begin
                    hold_req = 1'b1;
                end
                // Input side pauses until the block is empty
                if (p == 2 && k == 30) begin
                    wait_drained();
                end
                send_random_block();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Output side: check each transfer, then choose pop for the next cycle
    initial begin
        pixel_t      exp_px;
        int unsigned stall_left;
        int unsigned hold_left;
        bit          recv_burst;
        stall_left = 0;
        hold_left  = 0;
        recv_burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pop && !empty) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, index %0d", $time, o_pixel_index);
                    error_count++;
                end else begin
                    exp_px = pending_pixels.pop_front();
                    if (o_pixel_red !== exp_px.red) begin
                        $display("%0t: red exp %h act %h", $time, exp_px.red, o_pixel_red);
                        error_count++;
                    end
                    if (o_pixel_green !== exp_px.green) begin
                        $display("%0t: green exp %h act %h", $time, exp_px.green,
                                 o_pixel_green);
                        error_count++;
                    end
                    if (o_pixel_blue !== exp_px.blue) begin
                        $display("%0t: blue exp %h act %h", $time, exp_px.blue, o_pixel_blue);
                        error_count++;
                    end
                    if (o_pixel_alpha !== exp_px.alpha) begin
                        $display("%0t: alpha exp %h act %h", $time, exp_px.alpha,
                                 o_pixel_alpha);
                        error_count++;
                    end
                    if (o_pixel_index !== exp_px.index) begin
                        $display("%0t: index exp %0d act %0d", $time, exp_px.index,
                                 o_pixel_index);
                        error_count++;
                    end
                    if (o_last_pixel !== exp_px.last) begin
                        $display("%0t: last exp %b act %b", $time, exp_px.last,
                                 o_last_pixel);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                recv_burst = !recv_burst;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!recv_burst && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            @(posedge i_clk);
        end
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
